### hw/rtl/iis_pkg.sv
`timescale 1ns / 1ps

package iis_pkg;

	// Frame size limits and the width of the size registers
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int SIZE_W     = 13;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// Arithmetic widths
	localparam int PIX_W      = 8;
	localparam int ROWSUM_W   = 20;
	localparam int ROWSQ_W    = 28;
	localparam int SUM_W      = 32;
	localparam int SQ_W       = 41;
	localparam int SQ_OUT_W   = 40;
	localparam int LINE_W     = SUM_W + SQ_W;

	// Configuration port
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [SIZE_W-1:0] WIDTH_RST    = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] HEIGHT_RST   = SIZE_W'(480);
	localparam logic [SIZE_W-1:0] WIDTH_LIMIT  = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] HEIGHT_LIMIT = SIZE_W'(MAX_HEIGHT);

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// Control that travels with an item from acceptance to the write-back stage
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             row_nz;
		logic             last_col;
		logic             last_row;
	} item_ctl_t;

	// Clamp a size register to 1..limit
	function automatic logic [SIZE_W-1:0] clamp_size(
		input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] limit
	);
		logic [SIZE_W-1:0] r;
		if (v == '0)
			r = SIZE_W'(1);
		else if (v > limit)
			r = limit;
		else
			r = v;
		return r;
	endfunction

endpackage

### hw/rtl/integral_image_sum_sumsq.sv
`timescale 1ns / 1ps

// Streaming integral image with squared sum. Pixels arrive in raster order and each
// accepted pixel yields one result: the sum and the sum of squares of all pixels from
// the frame origin to that pixel, plus row_end and frame_end marks. The block takes one
// pixel every cycle unless a stalled result holds it back. That rate is set by the line
// store, a 4096 x 73 bit single-port-write RAM read at acceptance and written back as the
// item leaves stage 1, with a forwarding path for back-to-back hits on the same column
// (image width 1). A result is registered in stage 1 and then in the output register.
// The line store is not cleared after reset: the first row of every frame ignores it, so
// no clearing pass is needed. Size registers (width at 0x0, height at 0x4) reset to 640 x
// 480, treat 0 as 1 and clamp at 4096, and should only be written while the block is idle.
module integral_image_sum_sumsq (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [iis_pkg::APB_AW-1:0]    paddr,
	input  logic [iis_pkg::APB_DW-1:0]    pwdata,
	output logic [iis_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	// pixel channel
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  logic [iis_pkg::PIX_W-1:0]     pixel,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [iis_pkg::SUM_W-1:0]     prefix_sum,
	output logic [iis_pkg::SQ_OUT_W-1:0]  prefix_sum_sq,
	output logic                          row_end,
	output logic                          frame_end
);

	import iis_pkg::*;

	logic [SIZE_W-1:0]   width_q;
	logic [SIZE_W-1:0]   height_q;
	logic [SIZE_W-1:0]   w_eff;
	logic [SIZE_W-1:0]   h_eff;

	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [ROWSUM_W-1:0] rsum_q;
	logic [ROWSQ_W-1:0]  rsq_q;
	logic [ROWSUM_W-1:0] rsum_nxt;
	logic [ROWSQ_W-1:0]  rsq_nxt;
	logic [2*PIX_W-1:0]  pix_sq;
	logic                last_col;
	logic                last_row;

	logic                accept;
	logic                s1_valid;
	logic                s1_adv;
	item_ctl_t           ctl_s1;
	logic [ROWSUM_W-1:0] rsum_s1;
	logic [ROWSQ_W-1:0]  rsq_s1;
	logic                fwd_hit_s1;
	logic [LINE_W-1:0]   fwd_data_s1;

	logic [LINE_W-1:0]   line_rdata;
	logic [LINE_W-1:0]   above_raw;
	logic [SUM_W-1:0]    above;
	logic [SQ_W-1:0]     above_sq;
	logic [SUM_W-1:0]    total;
	logic [SQ_W-1:0]     total_sq;

	logic                out_valid_q;
	logic [SUM_W-1:0]    out_sum_q;
	logic [SQ_OUT_W-1:0] out_sq_q;
	logic                out_row_end_q;
	logic                out_frame_end_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[2]))
				REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign pready = 1'b1;

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			default:    prdata = '0;
		endcase
	end

	// Handshake: stage 1 drains into the output register when it is free
	assign s1_adv      = s1_valid && (!out_valid_q || !result_stall);
	assign pixel_stall = s1_valid && !s1_adv;
	assign accept      = pixel_valid && !pixel_stall;

	// Row running sums and position at acceptance
	assign w_eff    = clamp_size(width_q, WIDTH_LIMIT);
	assign h_eff    = clamp_size(height_q, HEIGHT_LIMIT);
	assign pix_sq   = pixel * pixel;
	assign rsum_nxt = rsum_q + ROWSUM_W'(pixel);
	assign rsq_nxt  = rsq_q + ROWSQ_W'(pix_sq);
	assign last_col = ({1'b0, col_q} + SIZE_W'(1)) >= w_eff;
	assign last_row = ({1'b0, row_q} + SIZE_W'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rsum_q <= '0;
			rsq_q  <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q  <= '0;
				rsum_q <= '0;
				rsq_q  <= '0;
				row_q  <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q  <= col_q + COL_W'(1);
				rsum_q <= rsum_nxt;
				rsq_q  <= rsq_nxt;
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (accept)
			s1_valid <= 1'b1;
		else if (s1_adv)
			s1_valid <= 1'b0;
	end

	// Stage 1 payload, plus forward of the write-back that collides with this read
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.col      <= col_q;
			ctl_s1.row_nz   <= (row_q != '0);
			ctl_s1.last_col <= last_col;
			ctl_s1.last_row <= last_row;
			rsum_s1         <= rsum_nxt;
			rsq_s1          <= rsq_nxt;
			fwd_hit_s1      <= s1_adv && (ctl_s1.col == col_q);
			fwd_data_s1     <= {total_sq, total};
		end
	end

	// Line store of the previous row's integrals
	iis_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (ctl_s1.col),
		.wdata ({total_sq, total}),
		.re    (accept),
		.raddr (col_q),
		.rdata (line_rdata)
	);

	// Add the row above, ignored on the first row
	assign above_raw = fwd_hit_s1 ? fwd_data_s1 : line_rdata;
	assign above     = ctl_s1.row_nz ? above_raw[SUM_W-1:0] : '0;
	assign above_sq  = ctl_s1.row_nz ? above_raw[LINE_W-1:SUM_W] : '0;
	assign total     = SUM_W'(rsum_s1) + above;
	assign total_sq  = SQ_W'(rsq_s1) + above_sq;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_sum_q       <= total;
			out_sq_q        <= total_sq[SQ_OUT_W-1:0];
			out_row_end_q   <= ctl_s1.last_col;
			out_frame_end_q <= ctl_s1.last_col && ctl_s1.last_row;
		end
	end

	assign result_valid  = out_valid_q;
	assign prefix_sum    = out_sum_q;
	assign prefix_sum_sq = out_sq_q;
	assign row_end       = out_row_end_q;
	assign frame_end     = out_frame_end_q;

endmodule

### hw/rtl/iis_ram.sv
`timescale 1ns / 1ps

module iis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; read returns old data on collision
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### hw/rtl/iis_checker.sv
`timescale 1ns / 1ps

module iis_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pixel_stall,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [iis_pkg::SUM_W-1:0]     prefix_sum,
	input logic [iis_pkg::SQ_OUT_W-1:0]  prefix_sum_sq,
	input logic                          row_end,
	input logic                          frame_end
);

	// A frame always ends on a row end
	a_frame_on_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_end |-> row_end)
		else $error("frame_end without row_end");

	// Input backs up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> result_valid && result_stall)
		else $error("pixel_stall with output free");

	// A held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(prefix_sum)
			&& $stable(prefix_sum_sq) && $stable(row_end) && $stable(frame_end))
		else $error("result changed under stall");

endmodule

bind integral_image_sum_sumsq iis_checker u_iis_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pixel_stall   (pixel_stall),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.prefix_sum    (prefix_sum),
	.prefix_sum_sq (prefix_sum_sq),
	.row_end       (row_end),
	.frame_end     (frame_end)
);

### tb/sv/tb_integral_image_sum_sumsq.sv
`timescale 1ns / 1ps

module tb_integral_image_sum_sumsq;
	import iis_pkg::*;

	localparam int RAND_ITEMS   = 1500;
	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE_LOOPS = 4;

	// One integral-image result as it leaves the block
	typedef struct packed {
		logic [SUM_W-1:0]    total;
		logic [SQ_OUT_W-1:0] total_sq;
		logic                row_last;
		logic                frame_last;
	} pix_sum_t;

	// One row of the directed table: a register write or a pixel
	typedef struct packed {
		logic        is_cfg;
		reg_idx_t    sel;
		logic [31:0] wdata;
		logic [7:0]  pix;
		logic        typed;
		pix_sum_t    want;
	} step_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                pixel_valid;
	logic                pixel_stall;
	logic [PIX_W-1:0]    pixel;
	logic                result_valid;
	logic                result_stall;
	logic [SUM_W-1:0]    prefix_sum;
	logic [SQ_OUT_W-1:0] prefix_sum_sq;
	logic                row_end;
	logic                frame_end;

	integral_image_sum_sumsq i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.pixel_valid   (pixel_valid),
		.pixel_stall   (pixel_stall),
		.pixel         (pixel),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.prefix_sum    (prefix_sum),
		.prefix_sum_sq (prefix_sum_sq),
		.row_end       (row_end),
		.frame_end     (frame_end)
	);

	// Integral-image tracker: size registers, scan position, row sums, line store
	logic [SIZE_W-1:0]   cfg_w = WIDTH_RST;
	logic [SIZE_W-1:0]   cfg_h = HEIGHT_RST;
	logic [COL_W-1:0]    col_pos = '0;
	logic [ROW_W-1:0]    row_pos = '0;
	logic [ROWSUM_W-1:0] run_sum = '0;
	logic [ROWSQ_W-1:0]  run_sq = '0;
	logic [SUM_W-1:0]    line_sum [MAX_WIDTH];
	logic [SQ_W-1:0]     line_sq [MAX_WIDTH];

	pix_sum_t sums_due [$];
	int       n_fail = 0;
	int       tx_pct = 0;
	int       rx_pct = 0;
	int       stall_left = 0;
	int       quiet_cyc = 0;
	logic     last_fe = 1'b0;

	// Size register as used: zero means one, anything above the limit means the limit
	function automatic int clip_dim(logic [SIZE_W-1:0] v, int lim);
		if (v == '0)
			return 1;
		if (int'(v) > lim)
			return lim;
		return int'(v);
	endfunction

	// Advance the tracker by one pixel and return the result it must produce
	function automatic pix_sum_t integrate_pixel(logic [7:0] p);
		pix_sum_t         r;
		logic [SUM_W-1:0] above;
		logic [SQ_W-1:0]  above_sq;
		logic [SUM_W-1:0] tot;
		logic [SQ_W-1:0]  tot_sq;
		logic             lc;
		logic             lr;
		run_sum = run_sum + p;
		run_sq  = run_sq + p * p;
		above    = '0;
		above_sq = '0;
		// first row of a frame ignores the line store
		if (row_pos != '0) begin
			above    = line_sum[col_pos];
			above_sq = line_sq[col_pos];
		end
		tot    = run_sum + above;
		tot_sq = run_sq + above_sq;
		line_sum[col_pos] = tot;
		line_sq[col_pos]  = tot_sq;
		lc = (int'(col_pos) + 1) >= clip_dim(cfg_w, MAX_WIDTH);
		lr = (int'(row_pos) + 1) >= clip_dim(cfg_h, MAX_HEIGHT);
		r.total      = tot;
		r.total_sq   = tot_sq[SQ_OUT_W-1:0];
		r.row_last   = lc;
		r.frame_last = lc && lr;
		if (lc) begin
			col_pos = '0;
			run_sum = '0;
			run_sq  = '0;
			row_pos = lr ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
		return r;
	endfunction

	// Random junk in the bits above the 13-bit size field
	function automatic logic [31:0] noisy(int v);
		logic [31:0] n;
		n = $urandom();
		return {n[31:SIZE_W], SIZE_W'(v)};
	endfunction

	function automatic step_t px(logic [7:0] p);
		step_t s;
		s = '0;
		s.pix = p;
		return s;
	endfunction

	function automatic step_t px_chk(logic [7:0] p, logic [31:0] t, logic [39:0] tq,
			logic re, logic fe);
		step_t s;
		s = px(p);
		s.typed = 1'b1;
		s.want  = '{total: t, total_sq: tq, row_last: re, frame_last: fe};
		return s;
	endfunction

	function automatic step_t cfg(reg_idx_t sel, logic [31:0] d);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.sel    = sel;
		s.wdata  = d;
		return s;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result-side stall bursts
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0)
				stall_left--;
			else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct)
				stall_left = $urandom_range(1, 14);
			result_stall <= (stall_left != 0);
		end
	end

	// Compare each accepted result with the oldest pending one
	always @(posedge clk) begin
		pix_sum_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (sums_due.size() == 0) begin
				$error("result with nothing pending: sum %0d sum_sq %0d", prefix_sum,
					prefix_sum_sq);
				n_fail++;
			end else begin
				e = sums_due.pop_front();
				if (prefix_sum !== e.total) begin
					$error("prefix_sum: expected %0d, got %0d", e.total, prefix_sum);
					n_fail++;
				end
				if (prefix_sum_sq !== e.total_sq) begin
					$error("prefix_sum_sq: expected %0d, got %0d", e.total_sq, prefix_sum_sq);
					n_fail++;
				end
				if (row_end !== e.row_last) begin
					$error("row_end: expected %0b, got %0b", e.row_last, row_end);
					n_fail++;
				end
				if (frame_end !== e.frame_last) begin
					$error("frame_end: expected %0b, got %0b", e.frame_last, frame_end);
					n_fail++;
				end
			end
		end
	end

	// Watchdog: too long with neither channel moving
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
			quiet_cyc = 0;
		else
			quiet_cyc++;
		if (quiet_cyc == QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stop sending and let every pending result drain
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_LOOPS) @(posedge clk);
	endtask

	// Write a size register while idle, then read it back
	task automatic cfg_write(reg_idx_t sel, logic [31:0] d);
		logic [31:0] rd;
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {{(32 - SIZE_W){1'b0}}, d[SIZE_W-1:0]}) begin
			$error("%s readback: expected %0d, got %0d", sel.name(), d[SIZE_W-1:0], rd);
			n_fail++;
		end
		if (sel == REG_WIDTH)
			cfg_w = d[SIZE_W-1:0];
		else
			cfg_h = d[SIZE_W-1:0];
	endtask

	// Offer one pixel, queue its result, hold until taken
	task automatic send_pixel(logic [7:0] p, logic typed, pix_sum_t want);
		pix_sum_t calc;
		if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		calc = integrate_pixel(p);
		sums_due.push_back(typed ? want : calc);
		last_fe = calc.frame_last;
		pixel_valid <= 1'b1;
		pixel       <= p;
		do @(posedge clk); while (pixel_stall);
	endtask

	initial begin
		step_t      tab [$];
		int         nrand;
		int         frame_no;
		int         k;
		int         forced_at;
		int         mode;
		logic [7:0] p;

		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		pixel_valid <= 1'b0;
		pixel       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: default size, shrink mid-row, zero height mid-frame, width one
		// back to back, zero width, oversized height cut short, then a small frame
		tab.push_back(px_chk(8'd255, 32'd255, 40'd65025, 1'b0, 1'b0));
		tab.push_back(px_chk(8'd0, 32'd255, 40'd65025, 1'b0, 1'b0));
		tab.push_back(px_chk(8'd255, 32'd510, 40'd130050, 1'b0, 1'b0));
		tab.push_back(cfg(REG_WIDTH, 32'd2));
		tab.push_back(px_chk(8'd1, 32'd511, 40'd130051, 1'b1, 1'b0));
		tab.push_back(cfg(REG_HEIGHT, 32'hFFFF_E000));
		tab.push_back(px(8'd255));
		tab.push_back(px(8'd255));
		tab.push_back(cfg(REG_WIDTH, 32'd1));
		tab.push_back(cfg(REG_HEIGHT, 32'd3));
		tab.push_back(px_chk(8'd255, 32'd255, 40'd65025, 1'b1, 1'b0));
		tab.push_back(px_chk(8'd255, 32'd510, 40'd130050, 1'b1, 1'b0));
		tab.push_back(px_chk(8'd255, 32'd765, 40'd195075, 1'b1, 1'b1));
		tab.push_back(cfg(REG_WIDTH, 32'hFFFF_E000));
		tab.push_back(cfg(REG_HEIGHT, 32'h0000_1FFF));
		tab.push_back(px(8'd0));
		tab.push_back(px(8'd128));
		tab.push_back(px(8'd7));
		tab.push_back(cfg(REG_HEIGHT, 32'd2));
		tab.push_back(px(8'd255));
		tab.push_back(cfg(REG_WIDTH, 32'd3));
		tab.push_back(cfg(REG_HEIGHT, 32'd2));
		for (int i = 1; i <= 6; i++)
			tab.push_back(px(8'(i)));

		tx_pct = 20;
		rx_pct = 20;
		foreach (tab[i]) begin
			if (tab[i].is_cfg)
				cfg_write(tab[i].sel, tab[i].wdata);
			else
				send_pixel(tab[i].pix, tab[i].typed, tab[i].want);
		end

		// Random frames until the item budget is spent
		nrand    = 0;
		frame_no = 0;
		while (nrand < RAND_ITEMS) begin
			if (nrand >= RAND_ITEMS - 300) begin
				tx_pct = 0;
				rx_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: tx_pct = 0;
					1: tx_pct = 10;
					2: tx_pct = 30;
					default: tx_pct = 60;
				endcase
				case ($urandom_range(0, 3))
					0: rx_pct = 0;
					1: rx_pct = 10;
					2: rx_pct = 30;
					default: rx_pct = 60;
				endcase
			end
			forced_at = -1;
			mode      = 2;
			if (frame_no == 2) begin
				// full-width limit, narrowed while still on the first row
				mode = 1;
				cfg_write(REG_WIDTH, noisy(MAX_WIDTH));
				cfg_write(REG_HEIGHT, noisy(2));
				forced_at = $urandom_range(1, 40);
			end else if (frame_no == 5) begin
				// full-height limit on a one-pixel column, cut short later
				mode = 0;
				cfg_write(REG_WIDTH, noisy(1));
				cfg_write(REG_HEIGHT, noisy(MAX_HEIGHT));
				forced_at = $urandom_range(5, 60);
			end else begin
				mode = $urandom_range(0, 9);
				if (mode == 0) begin
					// oversized height, cut short later
					cfg_write(REG_WIDTH, noisy($urandom_range(1, 8)));
					cfg_write(REG_HEIGHT, noisy($urandom_range(MAX_HEIGHT + 1, 8191)));
					forced_at = $urandom_range(5, 60);
				end else if (mode == 1) begin
					// oversized width, narrowed while still on the first row
					cfg_write(REG_WIDTH, noisy($urandom_range(MAX_WIDTH + 1, 8191)));
					cfg_write(REG_HEIGHT, noisy($urandom_range(1, 4)));
					forced_at = $urandom_range(1, 40);
				end else begin
					cfg_write(REG_WIDTH, noisy($urandom_range(0, 24)));
					cfg_write(REG_HEIGHT, noisy($urandom_range(0, 6)));
				end
			end

			k = 0;
			do begin
				if (k == forced_at) begin
					if (mode == 0)
						cfg_write(REG_HEIGHT, noisy($urandom_range(0, 3)));
					else if (row_pos == '0)
						cfg_write(REG_WIDTH, noisy($urandom_range(0, 20)));
					else
						cfg_write(REG_WIDTH,
							noisy($urandom_range(0, clip_dim(cfg_w, MAX_WIDTH))));
				end else if (k != 0 && $urandom_range(0, 299) == 0) begin
					// mid-frame resize; width may only grow on the first row
					if ($urandom_range(0, 1))
						cfg_write(REG_HEIGHT, noisy($urandom_range(0, 8)));
					else if (row_pos == '0)
						cfg_write(REG_WIDTH, noisy($urandom_range(0, 30)));
					else
						cfg_write(REG_WIDTH,
							noisy($urandom_range(0, clip_dim(cfg_w, MAX_WIDTH))));
				end else if ($urandom_range(0, 499) == 0) begin
					wait_idle();
				end
				case ($urandom_range(0, 9))
					0: p = 8'd0;
					1: p = 8'd255;
					default: p = 8'($urandom_range(0, 255));
				endcase
				send_pixel(p, 1'b0, '0);
				k++;
				nrand++;
			end while (!last_fe);
			frame_no++;
		end

		wait_idle();
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
